### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FVHC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FVHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/fvhc_pkg.sv
package fvhc_pkg;

  localparam int FLOW_W        = 16;
  localparam int CURVE_DEPTH_D = 1024;
  localparam int CI_W          = 10;
  localparam int SCALE_W       = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd5238;

  localparam int CORDIC_STEPS = 16;
  localparam int CORD_W       = FLOW_W + 17;   // |v|*2^14 plus CORDIC gain and sign
  localparam int ANG_W        = 27;            // degrees Q16, signed
  localparam int SQRT_STEPS   = FLOW_W + 8;    // root bits of (x^2+y^2)*2^16
  localparam int M2_W         = 2 * FLOW_W;

  typedef enum logic {
    OP_CONVERT  = 1'b0,
    OP_CURVE_WR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    op_t                      opcode;
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic [CI_W-1:0]          curve_index;
    logic [7:0]               curve_value;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  typedef struct packed {
    op_t             op;
    logic [CI_W-1:0] ci;
    logic [7:0]      cv;
  } meta_t;

  // side info riding along the CORDIC pipe
  typedef struct packed {
    logic neg;   // vector was turned by 180 degrees
    logic zero;  // zero vector, hue forced to 0
  } cordic_tag_t;

  // atan(2^-i) in degrees Q16
  function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned step);
    case (step)
      0:       return ANG_W'(2949120);
      1:       return ANG_W'(1740967);
      2:       return ANG_W'(919880);
      3:       return ANG_W'(466945);
      4:       return ANG_W'(234379);
      5:       return ANG_W'(117304);
      6:       return ANG_W'(58666);
      7:       return ANG_W'(29335);
      8:       return ANG_W'(14668);
      9:       return ANG_W'(7334);
      10:      return ANG_W'(3667);
      11:      return ANG_W'(1833);
      12:      return ANG_W'(917);
      13:      return ANG_W'(458);
      14:      return ANG_W'(229);
      15:      return ANG_W'(115);
      default: return '0;
    endcase
  endfunction

endpackage

### hw/rtl/fvhc_cordic.sv
module fvhc_cordic import fvhc_pkg::*; (
  input  logic                     clk,
  input  logic signed [CORD_W-1:0] x_in,
  input  logic signed [CORD_W-1:0] y_in,
  input  cordic_tag_t              tag_in,
  output logic signed [ANG_W-1:0]  z_out,
  output cordic_tag_t              tag_out
);

  logic signed [CORD_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0]  zs [0:CORDIC_STEPS];
  cordic_tag_t              tg [0:CORDIC_STEPS];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = '0;
  assign tg[0] = tag_in;

  // one micro-rotation per stage, rotating y toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!ys[i][CORD_W-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q16(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q16(i);
      end
      tg[i+1] <= tg[i];
    end
  end

  assign z_out   = zs[CORDIC_STEPS];
  assign tag_out = tg[CORDIC_STEPS];

endmodule

### hw/rtl/fvhc_sqrt.sv
module fvhc_sqrt import fvhc_pkg::*; (
  input  logic                  clk,
  input  logic [M2_W-1:0]       m2,
  output logic [SQRT_STEPS-1:0] root
);

  localparam int N   = SQRT_STEPS;
  localparam int RW  = N + 2;
  localparam int RDW = 2 * N;

  logic [RW-1:0]  rem_s [0:N];
  logic [N-1:0]   root_s [0:N];
  logic [RDW-1:0] rad_s [0:N];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = {m2, {(RDW-M2_W){1'b0}}};  // radicand scaled by 2^16

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < N; k++) begin : g_digit
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      cur   = {rem_s[k], rad_s[k][RDW-1 -: 2]};
      trial = (RW+2)'({root_s[k], 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      rem_s[k+1]  <= ge ? RW'(cur - trial) : RW'(cur);
      root_s[k+1] <= {root_s[k][N-2:0], ge};
      rad_s[k+1]  <= rad_s[k] << 2;
    end
  end

  assign root = root_s[N];

endmodule

### hw/rtl/flow_vector_to_hsv_color.sv
// Channel      Ports                   Transaction
// ------------ ----------------------- ----------------------------------------
// command      start, busy, cmd        taken at an edge with start high, busy low
// result       done, pixel             one cycle per pixel, done marks it
// config       cfg_we, cfg_wdata       magnitude_scale written when cfg_we high
//
// Fully pipelined: one command per cycle while busy is low. The depth is set
// by the 24-stage square root plus multiply, curve lookup and color stages.
// After rst the curve RAM is loaded with the linear ramp, one entry per cycle,
// with busy high; afterwards busy stays low.
// There is no back-pressure on results; curve writes pass through the pipe and
// update the RAM in order with conversions, so they never produce a result.
`include "assert_macros.svh"

module flow_vector_to_hsv_color import fvhc_pkg::*; #(
  parameter int CURVE_DEPTH = CURVE_DEPTH_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_t                cmd,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  output logic               done,
  output out_t               pixel
);

  localparam int CW   = $clog2(CURVE_DEPTH);
  localparam int IW   = (CW > CI_W) ? CW : CI_W;
  localparam int DEN  = 2 * (CURVE_DEPTH - 1);
  localparam int RSW  = $clog2(2 * CURVE_DEPTH) + 10;
  localparam int MD   = 26;               // stage holding the square root result
  localparam int HD   = MD - 18;          // hue delay line length after its stage
  localparam int PW   = SQRT_STEPS + SCALE_W;
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 * 65536);
  localparam logic signed [ANG_W-1:0] ONE_DEG   = ANG_W'(65536);
  localparam logic [13:0] RECIP30 = 14'd8739;   // ceil(2^18/30)

  // ---------------------------------------------------------------------------
  // magnitude scale register
  logic [SCALE_W-1:0] scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // curve RAM load after reset: entry i = round(255*i/(D-1)), stepped by
  // accumulating 510 per entry against 2*(D-1)
  logic            clr_active;
  logic [CW-1:0]   clr_addr;
  logic [7:0]      clr_val;
  logic [RSW-1:0]  clr_res;
  logic [RSW-1:0]  clr_res_next;
  logic [7:0]      clr_val_next;

  always_comb begin
    clr_res_next = clr_res + RSW'(510);
    clr_val_next = clr_val;
    for (int s = 0; s < 6; s++) begin
      if (clr_res_next >= RSW'(DEN)) begin
        clr_res_next = clr_res_next - RSW'(DEN);
        clr_val_next = clr_val_next + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      clr_val    <= '0;
      clr_res    <= RSW'(CURVE_DEPTH - 1);
    end else if (clr_active) begin
      if (clr_addr == CW'(CURVE_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + CW'(1);
        clr_val  <= clr_val_next;
        clr_res  <= clr_res_next;
      end
    end
  end

  assign busy = clr_active;

  // ---------------------------------------------------------------------------
  // control and payload pipes up to the root stage
  logic  vld_q  [0:MD];
  meta_t meta_q [0:MD];
  in_t   in_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= MD; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= start && !busy;
      for (int s = 1; s <= MD; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= cmd;
    meta_q[0] <= '{op: cmd.opcode, ci: cmd.curve_index, cv: cmd.curve_value};
    for (int s = 1; s <= MD; s++) meta_q[s] <= meta_q[s-1];
  end

  // stage 1: squares and CORDIC pre-rotation
  logic [FLOW_W-1:0]        ax;
  logic [FLOW_W-1:0]        ay;
  logic [M2_W-1:0]          sq_x;
  logic [M2_W-1:0]          sq_y;
  logic signed [CORD_W-1:0] fx;
  logic signed [CORD_W-1:0] fy;
  logic signed [CORD_W-1:0] cx;
  logic signed [CORD_W-1:0] cy;
  cordic_tag_t              ctag;
  logic [M2_W-1:0]          m2;

  always_comb begin
    ax = in_r.flow_x[FLOW_W-1] ? FLOW_W'(-in_r.flow_x) : FLOW_W'(in_r.flow_x);
    ay = in_r.flow_y[FLOW_W-1] ? FLOW_W'(-in_r.flow_y) : FLOW_W'(in_r.flow_y);
    fx = CORD_W'(in_r.flow_x);
    fy = CORD_W'(in_r.flow_y);
  end

  always_ff @(posedge clk) begin
    sq_x <= ax * ax;
    sq_y <= ay * ay;
    if (in_r.flow_x[FLOW_W-1]) begin
      cx <= (-fx) <<< 14;
      cy <= (-fy) <<< 14;
    end else begin
      cx <= fx <<< 14;
      cy <= fy <<< 14;
    end
    ctag.neg  <= in_r.flow_x[FLOW_W-1];
    ctag.zero <= (in_r.flow_x == '0) && (in_r.flow_y == '0);
  end

  // stage 2: squared magnitude
  always_ff @(posedge clk) begin
    m2 <= sq_x + sq_y;
  end

  // angle, stages 2..17
  logic signed [ANG_W-1:0] z_fin;
  cordic_tag_t             tag_fin;

  fvhc_cordic u_cordic (
    .clk     (clk),
    .x_in    (cx),
    .y_in    (cy),
    .tag_in  (ctag),
    .z_out   (z_fin),
    .tag_out (tag_fin)
  );

  // magnitude in Q8, stages 3..26
  logic [SQRT_STEPS-1:0] root;

  fvhc_sqrt u_sqrt (
    .clk  (clk),
    .m2   (m2),
    .root (root)
  );

  // stage 18: wrap the angle, halve and round it to the hue, then delay to stage 26
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] ang_r;
  logic [7:0]              hue_q [0:HD];

  always_comb begin
    ang = z_fin + (tag_fin.neg ? HALF_TURN : '0);
    if (ang < 0) begin
      ang = ang + FULL_TURN;
    end else if (ang >= FULL_TURN) begin
      ang = ang - FULL_TURN;
    end
    ang_r = ang + ONE_DEG;
  end

  always_ff @(posedge clk) begin
    hue_q[0] <= tag_fin.zero ? 8'd0 : ang_r[24:17];
    for (int s = 1; s <= HD; s++) hue_q[s] <= hue_q[s-1];
  end

  // ---------------------------------------------------------------------------
  // stage 27: magnitude times scale
  logic [PW-1:0] prod27;
  logic [7:0]    hue27;
  logic          vld27;
  meta_t         meta27;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld27 <= 1'b0;
    end else begin
      vld27 <= vld_q[MD];
    end
  end

  always_ff @(posedge clk) begin
    prod27 <= root * scale;
    hue27  <= hue_q[HD];
    meta27 <= meta_q[MD];
  end

  // stage 28: curve index, hue sector; RAM access at the end of this stage
  logic [PW:0]   rnd;
  logic [15:0]   hprod;
  logic [2:0]    sec_raw;
  logic [CW-1:0] idx28;
  sector_t       sec28;
  logic [4:0]    rem28;
  logic          vld28;
  meta_t         meta28;

  always_comb begin
    rnd     = (PW+1)'(prod27) + (PW+1)'(1 << 23);
    hprod   = hue27 * 8'd137;                 // hue/30 via reciprocal
    sec_raw = hprod[14:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld28 <= 1'b0;
    end else begin
      vld28 <= vld27;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd[PW:24] > (PW-23)'(CURVE_DEPTH - 1)) begin
      idx28 <= CW'(CURVE_DEPTH - 1);
    end else begin
      idx28 <= rnd[24 +: CW];
    end
    // hue of 180 folds back to pure red
    if (sec_raw >= 3'd6) begin
      sec28 <= SEC_RY;
      rem28 <= '0;
    end else begin
      sec28 <= sector_t'(sec_raw);
      rem28 <= 5'(hue27 - 8'(sec_raw) * 8'd30);
    end
    meta28 <= meta27;
  end

  // curve RAM
  logic [7:0]  curve_mem [CURVE_DEPTH];
  logic [IW-1:0] ci_ext;
  logic        wr_en;
  logic [7:0]  v29;

  always_comb begin
    ci_ext = IW'(meta28.ci);
    wr_en  = vld28 && (meta28.op == OP_CURVE_WR) &&
             ({1'b0, ci_ext} < (IW+1)'(CURVE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      curve_mem[clr_addr] <= clr_val;
    end else if (wr_en) begin
      curve_mem[ci_ext[CW-1:0]] <= meta28.cv;
    end
  end

  always_ff @(posedge clk) begin
    v29 <= curve_mem[idx28];
  end

  // stage 29: value ready
  logic    vld29;
  sector_t sec29;
  logic [4:0] rem29;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld29 <= 1'b0;
    end else begin
      vld29 <= vld28 && (meta28.op == OP_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    sec29 <= sec28;
    rem29 <= rem28;
  end

  // stage 30: rounded numerators of v*rem/30 and v*(30-rem)/30
  logic        vld30;
  logic [12:0] nt30;
  logic [12:0] nq30;
  logic [7:0]  v30;
  sector_t     sec30;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld30 <= 1'b0;
    end else begin
      vld30 <= vld29;
    end
  end

  always_ff @(posedge clk) begin
    nt30  <= 13'(v29) * 13'(rem29) + 13'd15;
    nq30  <= 13'(v29) * 13'(5'd30 - rem29) + 13'd15;
    v30   <= v29;
    sec30 <= sec29;
  end

  // stage 31: divide by 30 through the reciprocal
  logic        vld31;
  logic [26:0] pt31;
  logic [26:0] pq31;
  logic [7:0]  v31;
  sector_t     sec31;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld31 <= 1'b0;
    end else begin
      vld31 <= vld30;
    end
  end

  always_ff @(posedge clk) begin
    pt31  <= nt30 * RECIP30;
    pq31  <= nq30 * RECIP30;
    v31   <= v30;
    sec31 <= sec30;
  end

  // stage 32: six-sector HSV to RGB
  logic [7:0] t31;
  logic [7:0] q31;
  out_t       rgb;

  always_comb begin
    t31 = pt31[25:18];
    q31 = pq31[25:18];
    case (sec31)
      SEC_RY:  rgb = '{red: v31, green: t31, blue: 8'd0};
      SEC_YG:  rgb = '{red: q31, green: v31, blue: 8'd0};
      SEC_GC:  rgb = '{red: 8'd0, green: v31, blue: t31};
      SEC_CB:  rgb = '{red: 8'd0, green: q31, blue: v31};
      SEC_BM:  rgb = '{red: t31, green: 8'd0, blue: v31};
      default: rgb = '{red: v31, green: 8'd0, blue: q31};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld31;
    end
  end

  always_ff @(posedge clk) begin
    pixel <= rgb;
  end

  // ---------------------------------------------------------------------------
  // checks
  `FVHC_ASSERT(a_convert_lat, clk, rst, start && !busy && cmd.opcode == OP_CONVERT |-> ##33 done, "convert transaction gave no pixel")
  `FVHC_ASSERT(a_write_quiet, clk, rst, start && !busy && cmd.opcode == OP_CURVE_WR |-> ##33 !done, "curve write gave a pixel")
  `FVHC_ASSERT(a_busy_no_done, clk, rst, busy |-> !done, "pixel during curve load")
  `FVHC_ASSERT_ALWAYS(a_rst_load, clk, rst |=> busy, "curve load did not start after reset")

endmodule

### sim/tb_flow_vector_to_hsv_color.sv
`timescale 1ns / 100ps

module tb_flow_vector_to_hsv_color;
  import fvhc_pkg::*;

  // ---------------------------------------------------------------------------
  // Timing
  // ---------------------------------------------------------------------------
  // Let DRAIN_CYCLES pass after the last pixel before a register write or the
  // end check, because curve writes may still be in flight then.
  localparam int DRAIN_CYCLES = 48;
  localparam int RAND_ITEMS   = 1400;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  in_t                cmd;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;
  logic               done;
  out_t               pixel;

  flow_vector_to_hsv_color uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .pixel     (pixel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit. A clean run includes the curve fill that follows reset.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Color predictor: its own copy of the curve RAM and the scale register
  // ---------------------------------------------------------------------------
  logic [7:0]         curve_mirror [CURVE_DEPTH_D];
  logic [SCALE_W-1:0] scale_mirror;

  out_t pixel_queue [$];   // pixels still to come, oldest first
  int   mismatches;

  // Vector angle in degrees Q16, wrapped to [0,360). The vector runs through
  // 16 CORDIC rotations after it is scaled by 2^14.
  function automatic longint angle_deg_q16(longint fx, longint fy);
    longint base;
    longint z;
    longint dx;
    longint dy;
    longint a;
    base = 0;
    z = 0;
    if (fx == 0 && fy == 0) return 0;
    if (fx < 0) begin
      // left half: turn the vector by 180 degrees first
      fx = -fx;
      fy = -fy;
      base = 180 * 65536;
    end
    fx = fx * 16384;
    fy = fy * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fy >>> i;
      dy = fx >>> i;
      if (fy >= 0) begin
        fx += dx; fy -= dy; z += longint'(atan_q16(i));
      end else begin
        fx -= dx; fy += dy; z -= longint'(atan_q16(i));
      end
    end
    a = base + z;
    if (a < 0) a += 360 * 65536;
    if (a >= 360 * 65536) a -= 360 * 65536;
    return a;
  endfunction

  // floor(sqrt(m2) * 256), computed digit by digit
  function automatic longint unsigned mag_q8(longint unsigned m2);
    longint unsigned rmd;
    longint unsigned root;
    longint unsigned pr;
    longint unsigned trial;
    rmd = 0;
    root = 0;
    for (int p = 39; p >= 0; p--) begin
      pr = (p >= 8) ? ((m2 >> (2 * (p - 8))) & 64'd3) : 64'd0;
      rmd = (rmd << 2) | pr;
      trial = (root << 2) | 64'd1;
      if (rmd >= trial) begin
        rmd -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic out_t hsv_pixel(logic signed [FLOW_W-1:0] fx,
                                     logic signed [FLOW_W-1:0] fy);
    longint          x;
    longint          y;
    longint unsigned r;
    longint unsigned idx;
    longint unsigned v;
    longint unsigned hue;
    longint unsigned sec;
    longint unsigned rem;
    longint unsigned t;
    longint unsigned q;
    out_t            px;
    x = fx;
    y = fy;
    r = mag_q8(longint'(x * x + y * y));
    if (scale_mirror == 0)
      idx = 0;
    else if (r >= (64'(CURVE_DEPTH_D) << 24))
      idx = CURVE_DEPTH_D - 1;
    else
      idx = (r * scale_mirror + (64'd1 << 23)) >> 24;
    if (idx > CURVE_DEPTH_D - 1) idx = CURVE_DEPTH_D - 1;
    v = curve_mirror[idx];
    // halve and round the angle: hue 0..180, where 180 folds back to red
    hue = longint'((angle_deg_q16(x, y) + 65536) >>> 17);
    sec = hue / 30;
    rem = hue % 30;
    if (sec >= 6) sec = 0;
    t = (2 * v * rem + 30) / 60;
    q = (2 * v * (30 - rem) + 30) / 60;
    case (sector_t'(sec))
      SEC_RY:  px = '{red: 8'(v), green: 8'(t), blue: 8'd0};
      SEC_YG:  px = '{red: 8'(q), green: 8'(v), blue: 8'd0};
      SEC_GC:  px = '{red: 8'd0, green: 8'(v), blue: 8'(t)};
      SEC_CB:  px = '{red: 8'd0, green: 8'(q), blue: 8'(v)};
      SEC_BM:  px = '{red: 8'(t), green: 8'd0, blue: 8'(v)};
      default: px = '{red: 8'(v), green: 8'd0, blue: 8'(q)};
    endcase
    return px;
  endfunction

  // Applies one accepted command to the mirror. A conversion queues its pixel.
  function automatic void track_command(in_t c);
    if (c.opcode == OP_CURVE_WR) begin
      if (c.curve_index < CURVE_DEPTH_D) curve_mirror[c.curve_index] = c.curve_value;
    end else begin
      pixel_queue.push_back(hsv_pixel(c.flow_x, c.flow_y));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel checker. done is sampled at the rising edge, and there is no
  // back-pressure, so every cycle with done high is one transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", pixel);
      end else begin
        out_t want;
        want = pixel_queue.pop_front();
        if (pixel.red !== want.red || pixel.green !== want.green
            || pixel.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: want r%0d g%0d b%0d, got r%0d g%0d b%0d",
                     want.red, want.green, want.blue, pixel.red, pixel.green,
                     pixel.blue);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. Inputs change on the falling edge. A transaction is taken
  // at the rising edge with start high and busy low. The task returns on a
  // falling edge, so a back-to-back command keeps start high without a
  // second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(in_t c, bit typed, out_t want);
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed && c.opcode == OP_CONVERT) pixel_queue.push_back(want);
    else track_command(c);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Register writes happen only while idle: all pixels are back and the pipe
  // has had time to empty.
  task automatic write_scale(logic [SCALE_W-1:0] s);
    start <= 1'b0;
    wait (pixel_queue.size() == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale_mirror = s;
  endtask

  function automatic in_t make_cmd(op_t op, int fx, int fy, int ci, int cv);
    in_t c;
    c.opcode      = op;
    c.flow_x      = FLOW_W'(fx);
    c.flow_y      = FLOW_W'(fy);
    c.curve_index = CI_W'(ci);
    c.curve_value = 8'(cv);
    return c;
  endfunction

  // Random flow vector. Most use narrow magnitudes so that the curve index
  // lands inside the table; a few use the full range.
  function automatic in_t rand_convert();
    int w;
    int fx;
    int fy;
    w  = $urandom_range(2, FLOW_W);
    fx = $urandom_range(0, (1 << w) - 1) - (1 << (w - 1));
    fy = $urandom_range(0, (1 << w) - 1) - (1 << (w - 1));
    return make_cmd(OP_CONVERT, fx, fy, $urandom_range(0, 1023), $urandom_range(0, 255));
  endfunction

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  dir_row_t dir_table [$];

  function automatic void add_row(op_t op, int fx, int fy, int ci, int cv,
                                  bit typed = 0, out_t want = '0);
    dir_row_t row;
    row.item  = make_cmd(op, fx, fy, ci, cv);
    row.typed = typed;
    row.want  = want;
    dir_table.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SCALE_W-1:0] scales [6];
    in_t c;
    out_t no_px;
    int  done_items;

    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    no_px     = '0;
    for (int i = 0; i < CURVE_DEPTH_D; i++)
      curve_mirror[i] = 8'((510 * i + (CURVE_DEPTH_D - 1)) / (2 * (CURVE_DEPTH_D - 1)));
    scale_mirror = SCALE_RESET;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed rows. The zero vector and saturated x-axis vectors can be read
    // off directly; everything else goes through the predictor.
    add_row(OP_CONVERT, 0, 0, 0, 0, 1, '{red: 0, green: 0, blue: 0});
    add_row(OP_CONVERT, 32767, 0, 0, 0, 1, '{red: 255, green: 0, blue: 0});
    add_row(OP_CONVERT, -32768, 0, 0, 0);
    add_row(OP_CONVERT, 0, 32767, 0, 0);
    add_row(OP_CONVERT, 0, -32768, 0, 0);
    add_row(OP_CONVERT, -32768, -32768, 1023, 255);
    add_row(OP_CONVERT, 32767, 32767, 0, 0);
    add_row(OP_CONVERT, 256, 443, 0, 0);     // about 60 degrees
    add_row(OP_CONVERT, -256, 443, 0, 0);
    add_row(OP_CONVERT, -443, -256, 0, 0);
    add_row(OP_CONVERT, 443, -256, 0, 0);
    add_row(OP_CONVERT, 2000, -1, 0, 0);     // just below 360: hue 180 wraps
    add_row(OP_CONVERT, -1, 1, 0, 0);
    add_row(OP_CURVE_WR, 0, 0, 0, 255);
    add_row(OP_CURVE_WR, 0, 0, 1023, 170);
    add_row(OP_CONVERT, 0, 0, 0, 0, 1, '{red: 255, green: 0, blue: 0});
    add_row(OP_CONVERT, 32767, 0, 0, 0, 1, '{red: 170, green: 0, blue: 0});
    add_row(OP_CURVE_WR, -1, -1, 1023, 0);
    add_row(OP_CONVERT, 1200, 700, 0, 0);

    foreach (dir_table[i]) send_cmd(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

    // Zero scale pins the index to 0; then full scale is used on small vectors.
    write_scale('0);
    send_cmd(make_cmd(OP_CONVERT, 300, -200, 0, 0), 0, no_px);
    send_cmd(make_cmd(OP_CONVERT, 30000, -20000, 0, 0), 0, no_px);
    send_cmd(make_cmd(OP_CONVERT, -5, 7, 0, 0), 0, no_px);
    write_scale('1);
    send_cmd(make_cmd(OP_CONVERT, 1, 0, 0, 0), 0, no_px);
    send_cmd(make_cmd(OP_CONVERT, 0, 0, 0, 0), 0, no_px);

    // Random phases, each under a different scale, the reset value among them.
    scales[0] = SCALE_RESET;
    scales[1] = 24'd1;
    scales[2] = SCALE_W'($urandom_range(0, 24'hFFFFFF));
    scales[3] = 24'd65536;
    scales[4] = SCALE_W'($urandom_range(100, 20000));
    scales[5] = 24'hFFFFFF;
    done_items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(scales[ph]);
      for (int k = 0; k < RAND_ITEMS / 6; k++) begin
        if ($urandom_range(0, 99) < 15)
          c = make_cmd(OP_CURVE_WR, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 1023), $urandom_range(0, 255));
        else
          c = rand_convert();
        send_cmd(c, 0, no_px);
        done_items++;
        // sender gaps in bursts, none in the final stretch
        if (done_items < RAND_ITEMS - 200 && $urandom_range(0, 99) < 20)
          idle_gap($urandom_range(1, 10));
      end
    end

    start <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### flow_vector_to_hsv_color.f
+incdir+hw/rtl
hw/rtl/fvhc_pkg.sv
hw/rtl/fvhc_cordic.sv
hw/rtl/fvhc_sqrt.sv
hw/rtl/flow_vector_to_hsv_color.sv
sim/tb_flow_vector_to_hsv_color.sv
